// ===== design/rrls_pkg.sv =====
// ----------------------------------------------------------------------------
// rrls_pkg
// Shared types, codes and saturation helpers for the recursive residual
// least-squares unit.
// ----------------------------------------------------------------------------
package rrls_pkg;

    // item opcodes
    typedef enum logic [2:0] {
        OP_MATRIX   = 3'd0,
        OP_COEF     = 3'd1,
        OP_PREV_X   = 3'd2,
        OP_PREV_RES = 3'd3,
        OP_SCALE    = 3'd4,
        OP_NEW_X    = 3'd5,
        OP_RESPONSE = 3'd6
    } op_code_t;

    // regions of the vector memory, each one regressor count long
    localparam int unsigned RG_COEF = 0;
    localparam int unsigned RG_XP   = 1;
    localparam int unsigned RG_XN   = 2;
    localparam int unsigned RG_V    = 3;
    localparam int unsigned RG_W    = 4;
    localparam int unsigned RG_NUM  = 5;

    localparam logic signed [63:0] MAX32 = 64'sd2147483647;
    localparam logic signed [63:0] MIN32 = -64'sd2147483648;

    // request to the divide / square root unit
    typedef struct packed {
        logic               start;
        logic               sqrt_mode;
        logic signed [63:0] num;
        logic signed [31:0] den;
    } ds_req_t;

    // response from the divide / square root unit
    typedef struct packed {
        logic               done;
        logic signed [63:0] quo;
        logic               divz;
    } ds_rsp_t;

    // clamp to the 32-bit signed range
    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > MAX32)
            r = 32'sh7fffffff;
        else if (v < MIN32)
            r = 32'sh80000000;
        else
            r = v[31:0];
        return r;
    endfunction

    // true when sat32 would clamp
    function automatic logic ovf32(input logic signed [63:0] v);
        return (v > MAX32) || (v < MIN32);
    endfunction

endpackage

// ===== design/recursive_residual_rls_unit.sv =====
// ----------------------------------------------------------------------------
// recursive_residual_rls_unit
// Recursive least-squares engine producing standardized recursive residuals.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready): one item carries op, row_index,
// col_index and data_value. Load items write the inverse moment matrix,
// coefficients, previous row, previous residual or scale term; regressor
// items write the new row. Each is taken without leaving idle and gives no result.
// A response item starts the update and gives one result item (residual,
// scale_out, saturated) on the output channel (out_valid/out_ready).
// The matrix sits in one memory and all vectors in a second; one shared
// multiplier and one bit-serial divide / square root unit do the work.
// A response keeps the block busy, mostly in the divider, which runs once
// per matrix entry; no item is taken until the update is done.
// The result waits in an output register; loads are taken while it waits,
// and a following response holds at its end until the receiver takes the
// earlier result. Reset sets the previous residual to zero and the scale
// term to one; memory contents are undefined until loaded.
// ----------------------------------------------------------------------------
module recursive_residual_rls_unit
    import rrls_pkg::*;
#(
    parameter int NUM_REGRESSORS = 4,
    parameter int FRAC_BITS      = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [2:0]         op,
    input  logic [1:0]         row_index,
    input  logic [1:0]         col_index,
    input  logic signed [31:0] data_value,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] residual,
    output logic [30:0]        scale_out,
    output logic               saturated
);

    localparam int K     = NUM_REGRESSORS;
    localparam int IW    = (K > 1) ? $clog2(K) : 1;
    localparam int PDEP  = K * K;
    localparam int PAW   = (PDEP > 1) ? $clog2(PDEP) : 1;
    localparam int VDEP  = int'(RG_NUM) * K;
    localparam int VAW   = $clog2(VDEP);
    localparam logic [IW-1:0] LAST = IW'(K - 1);
    localparam logic signed [63:0] ONE_Q  = 64'sd1 <<< FRAC_BITS;
    localparam logic signed [63:0] HALF_Q = 64'sd1 <<< (FRAC_BITS - 1);

    typedef enum logic [3:0] {
        ST_IDLE, ST_DS_WAIT, ST_PA, ST_PB, ST_PC, ST_PMUL, ST_PACC,
        ST_CT_MUL1, ST_CT_RND1, ST_CT_MUL2, ST_CT_RND2, ST_CT_WR,
        ST_CP_RD, ST_CP_WR, ST_FIN
    } state_t;

    typedef enum logic [2:0] {PH_V, PH_W, PH_UPD, PH_COEF, PH_G, PH_F, PH_E} phase_t;
    typedef enum logic [1:0] {CX_S, CX_UPD, CX_SF, CX_E} ctx_t;

    state_t             state_reg;
    phase_t             phase_reg;
    ctx_t               ctx_reg;
    logic [IW-1:0]      i_reg;
    logic [IW-1:0]      j_reg;
    logic signed [63:0] acc_reg;
    logic signed [63:0] prod_reg;
    logic signed [31:0] opa_reg;
    logic signed [31:0] opb_reg;
    logic signed [31:0] t_reg;
    logic signed [31:0] r_reg;
    logic signed [31:0] f_reg;
    logic signed [31:0] s_reg;
    logic signed [31:0] y_reg;
    logic signed [31:0] fnew_reg;
    logic signed [31:0] e_reg;
    logic               sat_reg;
    logic               ds_start_reg;
    logic               ds_sqrt_reg;
    logic signed [63:0] ds_num_reg;
    logic signed [31:0] ds_den_reg;
    logic               out_valid_reg;
    logic signed [31:0] residual_reg;
    logic [30:0]        scale_reg;
    logic               sat_out_reg;

    ds_req_t ds_req;
    ds_rsp_t ds_rsp;

    logic               in_fire;
    logic               row_ok;
    logic               col_ok;
    logic               p_we;
    logic [PAW-1:0]     p_waddr;
    logic [PAW-1:0]     p_raddr;
    logic [31:0]        p_wdata;
    logic [31:0]        p_rdata_u;
    logic signed [31:0] p_rdata;
    logic               v_we;
    logic [VAW-1:0]     v_waddr;
    logic [VAW-1:0]     v_raddr;
    logic [31:0]        v_wdata;
    logic [31:0]        v_rdata_u;
    logic signed [31:0] v_rdata;
    logic [VAW-1:0]     va;
    logic [VAW-1:0]     vb;
    logic               a_from_p;
    logic               row_end;
    logic signed [31:0] mul_a;
    logic signed [31:0] mul_b;
    logic signed [63:0] rnd_prod;
    logic signed [63:0] acc_sum;
    logic signed [31:0] acc_s;
    logic signed [31:0] t_rnd_s;
    logic signed [63:0] coef_sum;
    logic signed [31:0] q_s;
    logic signed [63:0] p_diff;
    logic signed [63:0] e_diff;

    function automatic logic [VAW-1:0] vaddr(input int unsigned rg,
                                             input logic [IW-1:0] idx);
        return VAW'(rg * K + int'(idx));
    endfunction

    function automatic logic [PAW-1:0] paddr(input logic [IW-1:0] r,
                                             input logic [IW-1:0] c);
        return PAW'(int'(r) * K + int'(c));
    endfunction

    // state memories
    rrls_ram #(.WIDTH(32), .DEPTH(PDEP)) u_pmem (
        .clk   (clk),
        .we    (p_we),
        .waddr (p_waddr),
        .wdata (p_wdata),
        .raddr (p_raddr),
        .rdata (p_rdata_u)
    );

    rrls_ram #(.WIDTH(32), .DEPTH(VDEP)) u_vmem (
        .clk   (clk),
        .we    (v_we),
        .waddr (v_waddr),
        .wdata (v_wdata),
        .raddr (v_raddr),
        .rdata (v_rdata_u)
    );

    // shared divide and square root
    rrls_divsqrt #(.FRAC_BITS(FRAC_BITS)) u_ds (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (ds_req),
        .rsp   (ds_rsp)
    );

    assign ds_req.start     = ds_start_reg;
    assign ds_req.sqrt_mode = ds_sqrt_reg;
    assign ds_req.num       = ds_num_reg;
    assign ds_req.den       = ds_den_reg;

    assign in_ready = (state_reg == ST_IDLE);
    assign in_fire  = in_valid && in_ready;
    assign row_ok   = int'(row_index) < K;
    assign col_ok   = int'(col_index) < K;
    assign p_rdata  = $signed(p_rdata_u);
    assign v_rdata  = $signed(v_rdata_u);

    // operand addresses for the current phase
    always_comb
    begin
        a_from_p = phase_reg inside {PH_V, PH_W, PH_COEF, PH_G};
        if (phase_reg inside {PH_W, PH_G})
            p_raddr = paddr(j_reg, i_reg);
        else
            p_raddr = paddr(i_reg, j_reg);
        case (phase_reg)
            PH_UPD:  begin va = vaddr(RG_V, i_reg);  vb = vaddr(RG_W, j_reg);    end
            PH_G:    begin va = vaddr(RG_V, i_reg);  vb = vaddr(RG_XN, j_reg);   end
            PH_F:    begin va = vaddr(RG_V, i_reg);  vb = vaddr(RG_XN, i_reg);   end
            PH_E:    begin va = vaddr(RG_XN, i_reg); vb = vaddr(RG_COEF, i_reg); end
            default: begin va = vaddr(RG_V, i_reg);  vb = vaddr(RG_XP, j_reg);   end
        endcase
        case (state_reg) inside
            ST_PA:                                   v_raddr = va;
            ST_CT_MUL1, ST_CT_RND1, ST_CT_MUL2,
            ST_CT_RND2, ST_CT_WR:                    v_raddr = vaddr(RG_COEF, i_reg);
            ST_CP_RD, ST_CP_WR:                      v_raddr = vaddr(RG_XN, i_reg);
            default:                                 v_raddr = vb;
        endcase
    end

    // arithmetic around the shared multiplier
    always_comb
    begin
        case (state_reg)
            ST_CT_MUL1: begin mul_a = t_reg;   mul_b = r_reg;   end
            ST_CT_MUL2: begin mul_a = t_reg;   mul_b = s_reg;   end
            default:    begin mul_a = opa_reg; mul_b = opb_reg; end
        endcase
        rnd_prod = (prod_reg + HALF_Q) >>> FRAC_BITS;
        acc_sum  = acc_reg + rnd_prod;
        acc_s    = sat32(acc_sum);
        t_rnd_s  = sat32(rnd_prod);
        coef_sum = 64'(v_rdata) + 64'(t_reg);
        q_s      = sat32(ds_rsp.quo);
        p_diff   = 64'(p_rdata) - 64'(q_s);
        e_diff   = 64'(y_reg) - 64'(acc_s);
        row_end  = (state_reg == ST_PACC) && (j_reg == LAST)
                   && (phase_reg inside {PH_V, PH_W, PH_G});
    end

    // memory write ports
    always_comb
    begin
        p_we    = 1'b0;
        p_waddr = paddr(i_reg, j_reg);
        p_wdata = 32'(sat32(p_diff));
        v_we    = 1'b0;
        v_waddr = vaddr(RG_XP, i_reg);
        v_wdata = 32'(acc_s);
        if (state_reg == ST_IDLE)
        begin
            p_waddr = PAW'(int'(row_index) * K + int'(col_index));
            p_wdata = 32'(data_value);
            p_we    = in_fire && (op == OP_MATRIX) && row_ok && col_ok;
            v_wdata = 32'(data_value);
            v_we    = in_fire && row_ok
                      && ((op == OP_COEF) || (op == OP_PREV_X) || (op == OP_NEW_X));
            if (op == OP_COEF)
                v_waddr = VAW'(int'(RG_COEF) * K + int'(row_index));
            else if (op == OP_NEW_X)
                v_waddr = VAW'(int'(RG_XN) * K + int'(row_index));
            else
                v_waddr = VAW'(int'(RG_XP) * K + int'(row_index));
        end
        else if ((state_reg == ST_DS_WAIT) && (ctx_reg == CX_UPD))
        begin
            p_we = ds_rsp.done;
        end
        else if (row_end)
        begin
            v_we    = 1'b1;
            v_waddr = (phase_reg == PH_W) ? vaddr(RG_W, i_reg) : vaddr(RG_V, i_reg);
        end
        else if (state_reg == ST_CT_WR)
        begin
            v_we    = 1'b1;
            v_waddr = vaddr(RG_COEF, i_reg);
            v_wdata = 32'(sat32(coef_sum));
        end
        else if (state_reg == ST_CP_WR)
        begin
            v_we    = 1'b1;
            v_waddr = vaddr(RG_XP, i_reg);
            v_wdata = v_rdata_u;
        end
    end

    // main sequencer and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            phase_reg     <= PH_V;
            ctx_reg       <= CX_S;
            i_reg         <= '0;
            j_reg         <= '0;
            r_reg         <= '0;
            f_reg         <= 32'(ONE_Q);
            sat_reg       <= 1'b0;
            ds_start_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            ds_start_reg <= 1'b0;
            prod_reg     <= 64'(mul_a) * 64'(mul_b);
            if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_fire)
                    begin
                        case (op_code_t'(op))
                            OP_PREV_RES: r_reg <= data_value;
                            OP_SCALE:    f_reg <= data_value;
                            OP_RESPONSE:
                            begin
                                sat_reg      <= 1'b0;
                                y_reg        <= data_value;
                                i_reg        <= '0;
                                j_reg        <= '0;
                                ds_start_reg <= 1'b1;
                                ds_sqrt_reg  <= 1'b1;
                                ds_den_reg   <= f_reg;
                                ctx_reg      <= CX_S;
                                state_reg    <= ST_DS_WAIT;
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end
                ST_DS_WAIT:
                begin
                    if (ds_rsp.done)
                    begin
                        case (ctx_reg)
                            CX_S:
                            begin
                                s_reg     <= ds_rsp.quo[31:0];
                                phase_reg <= PH_V;
                                acc_reg   <= '0;
                                state_reg <= ST_PA;
                            end
                            CX_UPD:
                            begin
                                sat_reg <= sat_reg | ds_rsp.divz | ovf32(ds_rsp.quo)
                                           | ovf32(p_diff);
                                state_reg <= ST_PA;
                                if (j_reg != LAST)
                                begin
                                    j_reg <= j_reg + IW'(1);
                                end
                                else
                                begin
                                    j_reg <= '0;
                                    if (i_reg != LAST)
                                    begin
                                        i_reg <= i_reg + IW'(1);
                                    end
                                    else
                                    begin
                                        i_reg     <= '0;
                                        acc_reg   <= '0;
                                        phase_reg <= PH_COEF;
                                    end
                                end
                            end
                            CX_SF:
                            begin
                                ds_start_reg <= 1'b1;
                                ds_sqrt_reg  <= 1'b0;
                                ds_num_reg   <= 64'(e_reg) <<< FRAC_BITS;
                                ds_den_reg   <= ds_rsp.quo[31:0];
                                ctx_reg      <= CX_E;
                            end
                            default:
                            begin
                                e_reg     <= q_s;
                                sat_reg   <= sat_reg | ds_rsp.divz | ovf32(ds_rsp.quo);
                                i_reg     <= '0;
                                state_reg <= ST_CP_RD;
                            end
                        endcase
                    end
                end
                ST_PA:
                begin
                    state_reg <= ST_PB;
                end
                ST_PB:
                begin
                    opa_reg   <= a_from_p ? p_rdata : v_rdata;
                    state_reg <= ST_PC;
                end
                ST_PC:
                begin
                    opb_reg   <= v_rdata;
                    state_reg <= ST_PMUL;
                end
                ST_PMUL:
                begin
                    state_reg <= ST_PACC;
                end
                ST_PACC:
                begin
                    state_reg <= ST_PA;
                    case (phase_reg) inside
                        PH_V, PH_W, PH_G, PH_COEF:
                        begin
                            if (j_reg != LAST)
                            begin
                                acc_reg <= acc_sum;
                                j_reg   <= j_reg + IW'(1);
                            end
                            else if (phase_reg == PH_COEF)
                            begin
                                t_reg     <= acc_s;
                                sat_reg   <= sat_reg | ovf32(acc_sum);
                                state_reg <= ST_CT_MUL1;
                            end
                            else
                            begin
                                sat_reg <= sat_reg | ovf32(acc_sum);
                                j_reg   <= '0;
                                if (i_reg != LAST)
                                begin
                                    acc_reg <= '0;
                                    i_reg   <= i_reg + IW'(1);
                                end
                                else
                                begin
                                    i_reg <= '0;
                                    if (phase_reg == PH_V)
                                    begin
                                        acc_reg   <= '0;
                                        phase_reg <= PH_W;
                                    end
                                    else if (phase_reg == PH_W)
                                    begin
                                        acc_reg   <= '0;
                                        phase_reg <= PH_UPD;
                                    end
                                    else
                                    begin
                                        phase_reg <= PH_F;
                                        acc_reg   <= ONE_Q;
                                    end
                                end
                            end
                        end
                        PH_UPD:
                        begin
                            // scaled outer product entry over the old scale
                            ds_start_reg <= 1'b1;
                            ds_sqrt_reg  <= 1'b0;
                            ds_num_reg   <= rnd_prod <<< FRAC_BITS;
                            ds_den_reg   <= f_reg;
                            ctx_reg      <= CX_UPD;
                            state_reg    <= ST_DS_WAIT;
                        end
                        PH_F:
                        begin
                            if (i_reg != LAST)
                            begin
                                acc_reg <= acc_sum;
                                i_reg   <= i_reg + IW'(1);
                            end
                            else
                            begin
                                fnew_reg  <= acc_s;
                                sat_reg   <= sat_reg | ovf32(acc_sum);
                                acc_reg   <= '0;
                                i_reg     <= '0;
                                phase_reg <= PH_E;
                            end
                        end
                        PH_E:
                        begin
                            if (i_reg != LAST)
                            begin
                                acc_reg <= acc_sum;
                                i_reg   <= i_reg + IW'(1);
                            end
                            else
                            begin
                                // prediction error, then square root of the new scale
                                e_reg        <= sat32(e_diff);
                                sat_reg      <= sat_reg | ovf32(acc_sum) | ovf32(e_diff);
                                ds_start_reg <= 1'b1;
                                ds_sqrt_reg  <= 1'b1;
                                ds_den_reg   <= fnew_reg;
                                ctx_reg      <= CX_SF;
                                state_reg    <= ST_DS_WAIT;
                            end
                        end
                        default:
                        begin
                            state_reg <= ST_IDLE;
                        end
                    endcase
                end
                ST_CT_MUL1:
                begin
                    state_reg <= ST_CT_RND1;
                end
                ST_CT_RND1:
                begin
                    t_reg     <= t_rnd_s;
                    sat_reg   <= sat_reg | ovf32(rnd_prod);
                    state_reg <= ST_CT_MUL2;
                end
                ST_CT_MUL2:
                begin
                    state_reg <= ST_CT_RND2;
                end
                ST_CT_RND2:
                begin
                    t_reg     <= t_rnd_s;
                    sat_reg   <= sat_reg | ovf32(rnd_prod);
                    state_reg <= ST_CT_WR;
                end
                ST_CT_WR:
                begin
                    sat_reg   <= sat_reg | ovf32(coef_sum);
                    acc_reg   <= '0;
                    j_reg     <= '0;
                    state_reg <= ST_PA;
                    if (i_reg != LAST)
                    begin
                        i_reg <= i_reg + IW'(1);
                    end
                    else
                    begin
                        i_reg     <= '0;
                        phase_reg <= PH_G;
                    end
                end
                ST_CP_RD:
                begin
                    state_reg <= ST_CP_WR;
                end
                ST_CP_WR:
                begin
                    if (i_reg != LAST)
                    begin
                        i_reg     <= i_reg + IW'(1);
                        state_reg <= ST_CP_RD;
                    end
                    else
                    begin
                        state_reg <= ST_FIN;
                    end
                end
                ST_FIN:
                begin
                    if (!out_valid_reg || out_ready)
                    begin
                        r_reg         <= e_reg;
                        f_reg         <= fnew_reg;
                        residual_reg  <= e_reg;
                        scale_reg     <= fnew_reg[31] ? 31'd0 : fnew_reg[30:0];
                        sat_out_reg   <= sat_reg | fnew_reg[31];
                        out_valid_reg <= 1'b1;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign out_valid = out_valid_reg;
    assign residual  = residual_reg;
    assign scale_out = scale_reg;
    assign saturated = sat_out_reg;

endmodule

// ===== design/rrls_ram.sv =====
// ----------------------------------------------------------------------------
// rrls_ram
// Generic single-write, single-read memory with a registered read port.
// ----------------------------------------------------------------------------
module rrls_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== design/rrls_divsqrt.sv =====
// ----------------------------------------------------------------------------
// rrls_divsqrt
// Bit-serial unit: rounded signed division (one quotient bit a cycle) and
// integer square root of a fixed-point value (one result bit a cycle).
// ----------------------------------------------------------------------------
module rrls_divsqrt
    import rrls_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic    clk,
    input  logic    rst_n,
    input  ds_req_t req,
    output ds_rsp_t rsp
);

    typedef enum logic [1:0] {DS_IDLE, DS_DIV, DS_SQRT} ds_state_t;

    ds_state_t          state_reg;
    logic [5:0]         cnt_reg;
    logic [63:0]        un_reg;
    logic [31:0]        ud_reg;
    logic [31:0]        rem_reg;
    logic [63:0]        q_reg;
    logic [63:0]        bit_reg;
    logic               neg_reg;
    logic               done_reg;
    logic               divz_reg;
    logic signed [63:0] quo_reg;

    logic [63:0] un_abs;
    logic [31:0] ud_abs;
    logic [32:0] rem_sh;
    logic [32:0] rem_sub;
    logic        rem_fits;
    logic [63:0] q_fin;
    logic [63:0] sq_try;
    logic        sq_fits;
    logic [63:0] sq_res;

    // operand magnitudes and one step of each iteration
    always_comb
    begin
        un_abs   = req.num[63] ? 64'(-req.num) : 64'(req.num);
        ud_abs   = req.den[31] ? 32'(-req.den) : 32'(req.den);
        rem_sh   = {rem_reg, un_reg[63]};
        rem_sub  = rem_sh - {1'b0, ud_reg};
        rem_fits = rem_sh >= {1'b0, ud_reg};
        q_fin    = {q_reg[62:0], rem_fits};
        sq_try   = q_reg + bit_reg;
        sq_fits  = un_reg >= sq_try;
        sq_res   = sq_fits ? ((q_reg >> 1) + bit_reg) : (q_reg >> 1);
    end

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= DS_IDLE;
            done_reg  <= 1'b0;
            divz_reg  <= 1'b0;
            cnt_reg   <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                DS_IDLE:
                begin
                    if (req.start)
                    begin
                        divz_reg <= 1'b0;
                        q_reg    <= '0;
                        rem_reg  <= '0;
                        if (req.sqrt_mode)
                        begin
                            // nonpositive radicand gives zero
                            if (req.den[31] || (req.den == '0))
                            begin
                                quo_reg  <= '0;
                                done_reg <= 1'b1;
                            end
                            else
                            begin
                                un_reg    <= {33'b0, req.den[30:0]} << FRAC_BITS;
                                bit_reg   <= 64'h4000_0000_0000_0000;
                                cnt_reg   <= 6'd31;
                                state_reg <= DS_SQRT;
                            end
                        end
                        else if (req.den == '0)
                        begin
                            // division by zero saturates toward the numerator sign
                            divz_reg <= 1'b1;
                            done_reg <= 1'b1;
                            if (req.num > 64'sd0)
                                quo_reg <= MAX32;
                            else if (req.num < 64'sd0)
                                quo_reg <= MIN32;
                            else
                                quo_reg <= '0;
                        end
                        else
                        begin
                            un_reg    <= un_abs + {33'b0, ud_abs[31:1]};
                            ud_reg    <= ud_abs;
                            neg_reg   <= req.num[63] ^ req.den[31];
                            cnt_reg   <= 6'd63;
                            state_reg <= DS_DIV;
                        end
                    end
                end
                DS_DIV:
                begin
                    rem_reg <= rem_fits ? rem_sub[31:0] : rem_sh[31:0];
                    q_reg   <= q_fin;
                    un_reg  <= un_reg << 1;
                    cnt_reg <= cnt_reg - 6'd1;
                    if (cnt_reg == '0)
                    begin
                        quo_reg   <= neg_reg ? -$signed(q_fin) : $signed(q_fin);
                        done_reg  <= 1'b1;
                        state_reg <= DS_IDLE;
                    end
                end
                DS_SQRT:
                begin
                    if (sq_fits)
                    begin
                        un_reg <= un_reg - sq_try;
                    end
                    q_reg   <= sq_res;
                    bit_reg <= bit_reg >> 2;
                    cnt_reg <= cnt_reg - 6'd1;
                    if (cnt_reg == '0)
                    begin
                        quo_reg   <= $signed({32'b0, sq_res[31:0]});
                        done_reg  <= 1'b1;
                        state_reg <= DS_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= DS_IDLE;
                end
            endcase
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quo  = quo_reg;
    assign rsp.divz = divz_reg;

endmodule

// ===== design/rrls_checker.sv =====
// ----------------------------------------------------------------------------
// rrls_checker
// Port-level checks on the recursive residual unit, bound to the top level.
// ----------------------------------------------------------------------------
module rrls_checker
    import rrls_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input logic [2:0]         op,
    input logic [1:0]         row_index,
    input logic [1:0]         col_index,
    input logic signed [31:0] data_value,
    input logic               out_valid,
    input logic               out_ready,
    input logic signed [31:0] residual,
    input logic [30:0]        scale_out,
    input logic               saturated
);

    // a stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(residual)
            && $stable(scale_out) && $stable(saturated))
        else $error("result changed while stalled");

    // a response item makes the block busy
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (op == OP_RESPONSE) |=> !in_ready)
        else $error("input taken right after a response item");

    // load items leave the input ready
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (op != OP_RESPONSE) |=> in_ready)
        else $error("load item stalled the input");

    // a new result appears as the block returns to idle
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> in_ready)
        else $error("result raised while busy");

endmodule

bind recursive_residual_rls_unit rrls_checker u_rrls_checker (.*);
